>>> design/lsdn_pkg.sv
package lsdn_pkg;

  localparam int unsigned NUM_CH       = 4;
  localparam int unsigned SAMPLE_W     = 12;
  localparam int unsigned SUM_W        = 16;
  localparam int unsigned LEVEL_W      = 12;
  localparam int unsigned TOTAL_W      = LEVEL_W + 2;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 12;
  localparam int unsigned ROUNDS_DEF   = 15;

  // Fixed-point shift used for the reciprocal multiply in each lane.
  localparam int unsigned DIV_SHIFT    = 24;

  localparam logic [LEVEL_W-1:0] DAY_CUTOFF_RST      = 12'd100;
  localparam logic [LEVEL_W-1:0] INVERTED_CUTOFF_RST = 12'd3000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DAY_CUTOFF      = 2'd0,
    CFG_INVERTED_CUTOFF = 2'd1,
    CFG_INVERT_ENABLE   = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MODE_DAY     = 2'd0,
    MODE_NIGHT   = 2'd1,
    MODE_UNKNOWN = 2'd2
  } mode_e;

  typedef struct packed {
    logic [LEVEL_W-1:0] day_cutoff;
    logic [LEVEL_W-1:0] inverted_cutoff;
    logic               invert_enable;
  } cfg_t;

  typedef struct packed {
    logic acc;        // an item is accepted this cycle
    logic last;       // the accepted item closes the window
    logic load_quot;  // the quotient stage takes a finished sum
  } lane_ctrl_t;

endpackage

>>> design/lsdn_if.sv
interface lsdn_in_if;
  logic                             valid;
  logic                             ready;
  logic [lsdn_pkg::SAMPLE_W-1:0]    channel_a;
  logic [lsdn_pkg::SAMPLE_W-1:0]    channel_b;
  logic [lsdn_pkg::SAMPLE_W-1:0]    channel_c;
  logic [lsdn_pkg::SAMPLE_W-1:0]    channel_d;

  modport source (output valid, channel_a, channel_b, channel_c, channel_d, input ready);
  modport sink   (input valid, channel_a, channel_b, channel_c, channel_d, output ready);
endinterface

interface lsdn_out_if;
  logic                            valid;
  logic                            ready;
  logic [lsdn_pkg::LEVEL_W-1:0]    light_level;
  logic                            night_mode;
  logic                            mode_switched;

  modport source (output valid, light_level, night_mode, mode_switched, input ready);
  modport sink   (input valid, light_level, night_mode, mode_switched, output ready);
endinterface

interface lsdn_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [lsdn_pkg::CFG_IDX_W-1:0]    index;
  logic [lsdn_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> design/lsdn_lane.sv
module lsdn_lane #(
  parameter int unsigned ROUNDS = lsdn_pkg::ROUNDS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lsdn_pkg::lane_ctrl_t          ctrl_i,
  input  logic [lsdn_pkg::SAMPLE_W-1:0] sample_i,
  output logic [lsdn_pkg::LEVEL_W-1:0]  quot_o
);

  localparam int unsigned SUM_W   = lsdn_pkg::SUM_W;
  localparam int unsigned RECIP_W = lsdn_pkg::DIV_SHIFT + 1;
  localparam int unsigned PROD_W  = SUM_W + RECIP_W;
  // Rounded-up reciprocal; exact for every sum a window can produce.
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'((2 ** lsdn_pkg::DIV_SHIFT + ROUNDS - 1) / ROUNDS);

  logic [SUM_W-1:0]            sum_q, sum_d;
  logic [SUM_W-1:0]            fin_q;
  logic [lsdn_pkg::LEVEL_W-1:0] quot_q;
  logic [PROD_W-1:0]           prod;

  assign sum_d = sum_q + SUM_W'(sample_i);
  assign prod  = PROD_W'(fin_q) * PROD_W'(RECIP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (ctrl_i.acc) begin
      sum_q <= ctrl_i.last ? '0 : sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.acc && ctrl_i.last) begin
      fin_q <= sum_d;
    end
    if (ctrl_i.load_quot) begin
      quot_q <= prod[lsdn_pkg::DIV_SHIFT +: lsdn_pkg::LEVEL_W];
    end
  end

  assign quot_o = quot_q;

endmodule

>>> design/lsdn_merge.sv
module lsdn_merge (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         adv_i,
  input  logic                         valid_i,
  input  lsdn_pkg::cfg_t               cfg_i,
  input  logic [lsdn_pkg::LEVEL_W-1:0] quot_i [lsdn_pkg::NUM_CH],
  output logic                         valid_o,
  output logic [lsdn_pkg::LEVEL_W-1:0] level_o,
  output logic                         night_o,
  output logic                         switched_o
);

  localparam int unsigned TOTAL_W = lsdn_pkg::TOTAL_W;

  logic [TOTAL_W-1:0]           total;
  logic [lsdn_pkg::LEVEL_W-1:0] level;
  logic                         day;
  lsdn_pkg::mode_e              decided;
  lsdn_pkg::mode_e              mode_q;
  logic                         valid_q;
  logic [lsdn_pkg::LEVEL_W-1:0] level_q;
  logic                         night_q;
  logic                         switched_q;

  always_comb begin
    total = '0;
    for (int i = 0; i < lsdn_pkg::NUM_CH; i++) begin
      total = total + TOTAL_W'(quot_i[i]);
    end
  end

  assign level   = total[TOTAL_W-1:2];
  assign day     = (cfg_i.invert_enable && (level > cfg_i.inverted_cutoff)) ||
                   (level < cfg_i.day_cutoff);
  assign decided = day ? lsdn_pkg::MODE_DAY : lsdn_pkg::MODE_NIGHT;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      mode_q  <= lsdn_pkg::MODE_UNKNOWN;
    end else if (adv_i) begin
      valid_q <= valid_i;
      if (valid_i) begin
        mode_q <= decided;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && valid_i) begin
      level_q    <= level;
      night_q    <= (decided == lsdn_pkg::MODE_NIGHT);
      switched_q <= (decided != mode_q);
    end
  end

  assign valid_o    = valid_q;
  assign level_o    = level_q;
  assign night_o    = night_q;
  assign switched_o = switched_q;

endmodule

>>> design/light_sensor_day_night_select_top.sv
// Day/night selector: each item carries one reading of four 12-bit light channels, and after
// every ROUNDS items one result comes out with the window's light level, the chosen mode and
// a flag raised when that mode differs from the previous decision (always on the first
// result after reset). One item is accepted every clock cycle; the only stall is a result
// waiting at the output. Once the item closing its window is accepted, the result moves through
// registers in order: the finished sums in the per-channel accumulator lanes, each lane's
// reciprocal-multiply quotient, then the merging stage that averages and compares, whose
// output is offered. Configuration writes are taken at any time and are meant to change only
// while the block is idle.
module light_sensor_day_night_select_top #(
  parameter int unsigned ROUNDS = lsdn_pkg::ROUNDS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lsdn_in_if.sink    in_i,
  lsdn_cfg_if.sink   cfg_i,
  lsdn_out_if.source out_o
);

  localparam int unsigned CNT_W = $clog2(ROUNDS + 1);

  logic                         adv;
  logic                         acc;
  logic                         last;
  logic [CNT_W-1:0]             cnt_q;
  logic                         v1_q;
  logic                         v2_q;
  lsdn_pkg::lane_ctrl_t         lane_ctrl;
  lsdn_pkg::cfg_t               cfg_q;
  logic [lsdn_pkg::SAMPLE_W-1:0] samples [lsdn_pkg::NUM_CH];
  logic [lsdn_pkg::LEVEL_W-1:0] quots   [lsdn_pkg::NUM_CH];

  // The whole pipeline moves unless a result is held at the output.
  assign adv        = !out_o.valid || out_o.ready;
  assign in_i.ready = adv;
  assign acc        = in_i.valid && adv;
  assign last       = (cnt_q == CNT_W'(ROUNDS - 1));

  assign lane_ctrl.acc       = acc;
  assign lane_ctrl.last      = last;
  assign lane_ctrl.load_quot = adv && v1_q;

  assign samples[0] = in_i.channel_a;
  assign samples[1] = in_i.channel_b;
  assign samples[2] = in_i.channel_c;
  assign samples[3] = in_i.channel_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
    end else begin
      if (acc) begin
        cnt_q <= last ? '0 : cnt_q + 1'b1;
      end
      if (adv) begin
        v1_q <= acc && last;
        v2_q <= v1_q;
      end
    end
  end

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.day_cutoff      <= lsdn_pkg::DAY_CUTOFF_RST;
      cfg_q.inverted_cutoff <= lsdn_pkg::INVERTED_CUTOFF_RST;
      cfg_q.invert_enable   <= 1'b0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        lsdn_pkg::CFG_DAY_CUTOFF:      cfg_q.day_cutoff      <= cfg_i.data;
        lsdn_pkg::CFG_INVERTED_CUTOFF: cfg_q.inverted_cutoff <= cfg_i.data;
        lsdn_pkg::CFG_INVERT_ENABLE:   cfg_q.invert_enable   <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  for (genvar g = 0; g < lsdn_pkg::NUM_CH; g++) begin : g_lane
    lsdn_lane #(
      .ROUNDS(ROUNDS)
    ) u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (lane_ctrl),
      .sample_i(samples[g]),
      .quot_o  (quots[g])
    );
  end

  lsdn_merge u_merge (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .valid_i   (v2_q),
    .cfg_i     (cfg_q),
    .quot_i    (quots),
    .valid_o   (out_o.valid),
    .level_o   (out_o.light_level),
    .night_o   (out_o.night_mode),
    .switched_o(out_o.mode_switched)
  );

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q < CNT_W'(ROUNDS))
    else $error("window counter ran past the window length");

  a_window_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && last) |=> (v1_q && (cnt_q == '0)))
    else $error("closing item did not start the divide stage and restart the count");

  a_merge_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && v2_q) |=> out_o.valid)
    else $error("merged result did not reach the output");
`endif

endmodule
